// File: sv/lzwsd_pkg.sv
// Shared constants, codes and state types of the LZW stream decompressor.
package lzwsd_pkg;

  localparam int MAX_BITS   = 12;
  localparam int MAX_STRING = 64;

  localparam int CODE_W     = MAX_BITS;
  localparam int NFC_W      = MAX_BITS + 1;
  localparam int DICT_DEPTH = 1 << MAX_BITS;
  localparam int CW_W       = $clog2(MAX_BITS + 1);
  localparam int STK_AW     = $clog2(MAX_STRING);
  localparam int LEN_W      = STK_AW + 1;
  localparam int ACC_W      = 24;
  localparam int BITS_W     = 5;
  localparam int FIRST_CODE = 256;
  localparam int MIN_BITS   = 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TAG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 2'd2;

  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_BAD_TAG = 2'd1;
  localparam logic [1:0] ST_END     = 2'd2;
  localparam logic [1:0] ST_OVF     = 2'd3;

  typedef enum logic [2:0] {
    PH_TAG_HI, PH_TAG_LO, PH_FIRST, PH_DECODE, PH_DRAIN, PH_SKIP
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LIT, S_DSTART, S_WALK, S_TAIL, S_POP_RD, S_POP, S_FINISH, S_EMIT1
  } state_t;

endpackage

// File: sv/lzwsd_in_if.sv
// Input channel carrying compressed stream bytes.
interface lzwsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

// File: sv/lzwsd_out_if.sv
// Result channel carrying decoded bytes and status.
interface lzwsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_string;
  logic [1:0] status;
  modport source (output valid, output out_byte, output end_of_string, output status,
                  input ready);
  modport sink (input valid, input out_byte, input end_of_string, input status,
                output ready);
endinterface

// File: sv/lzwsd_cfg_if.sv
// Configuration write channel carrying a register index and write data.
interface lzwsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/lzw_stream_decompressor_core.sv
// Top level of the LZW stream decompressor with its sequencer and dictionary memories.
// A header, skipped or partial-code byte is handled in S_IDLE, plus S_EMIT1 if it gives a
// status. A code-completing byte visits S_DSTART, S_WALK per chain entry, S_TAIL, S_POP_RD,
// S_POP per string byte and S_FINISH (S_LIT, S_FINISH for the first code), S_EMIT1 with
// last_byte; output stalls add waiting. A byte is taken only when the sequencer is idle.
// Reset: rst_n is synchronous and active low; it restores configuration and stream state.
module lzw_stream_decompressor_core
  import lzwsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  lzwsd_in_if.sink    in_ch,
  lzwsd_out_if.source out_ch,
  lzwsd_cfg_if.sink   cfg_ch
);

  logic [15:0] tag_r;
  logic [3:0]  start_bits_r, max_bits_r;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [7:0]        tag_high_r, tag_high_nxt;
  logic [CW_W-1:0]   smax_r, smax_nxt, cw_r, cw_nxt;
  logic [NFC_W-1:0]  limit_r, limit_nxt, nfree_r, nfree_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt, code_r, code_nxt, c_r, c_nxt;
  logic [7:0]        lfc_r, lfc_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [BITS_W-1:0] bits_r, bits_nxt;
  logic [CW_W-1:0]   grp_r, grp_nxt;
  logic              last_r, last_nxt, add_r, add_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [STK_AW-1:0] idx_r, idx_nxt;
  logic [1:0]        pend_r, pend_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_eos_r;
  logic [1:0] out_status_r;
  logic       load_en, load_eos;
  logic [7:0] load_byte;
  logic [1:0] load_status;

  logic [CODE_W-1:0] prefix_mem [DICT_DEPTH];
  logic [7:0]        suffix_mem [DICT_DEPTH];
  logic [7:0]        stack_mem  [MAX_STRING];
  logic [CODE_W-1:0] pfx_q, dict_raddr;
  logic [7:0]        sfx_q, stk_q, stk_wdata;
  logic              dict_we, stk_we;
  logic [STK_AW-1:0] stk_waddr, stk_raddr;

  logic accept, slot_free;
  logic [CW_W-1:0]   grp_start, grp_dec, m_clamp, s_clamp, cw_inc;
  logic [ACC_W-1:0]  acc_new, code_sh;
  logic [BITS_W-1:0] bits_new, shamt;
  logic              have_code, grow, do_add;
  logic [CODE_W-1:0] code_val, c_sel;
  logic [NFC_W-1:0]  full_code, nf_after;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign slot_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.end_of_string = out_eos_r;
  assign out_ch.status        = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r        <= '0;
      start_bits_r <= 4'(MIN_BITS);
      max_bits_r   <= 4'(MAX_BITS);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TAG:   tag_r        <= cfg_ch.data;
        CFG_START: start_bits_r <= cfg_ch.data[3:0];
        CFG_MAX:   max_bits_r   <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dict_we) begin
      prefix_mem[nfree_r[CODE_W-1:0]] <= prev_r;
      suffix_mem[nfree_r[CODE_W-1:0]] <= lfc_r;
    end
    pfx_q <= prefix_mem[dict_raddr];
    sfx_q <= suffix_mem[dict_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stack_mem[stk_raddr];
  end

  always_comb begin
    m_clamp = (max_bits_r < 4'(MIN_BITS)) ? CW_W'(MIN_BITS) :
              (max_bits_r > 4'(MAX_BITS)) ? CW_W'(MAX_BITS) : CW_W'(max_bits_r);
    s_clamp = (start_bits_r < 4'(MIN_BITS)) ? CW_W'(MIN_BITS) : CW_W'(start_bits_r);
    if (s_clamp > m_clamp) s_clamp = m_clamp;

    grp_start = (grp_r == '0) ? cw_r : grp_r;
    grp_dec   = grp_start - 1'b1;
    acc_new   = {acc_r[ACC_W-9:0], in_ch.in_byte};
    bits_new  = bits_r + BITS_W'(8);
    have_code = (bits_new >= BITS_W'(cw_r));
    shamt     = bits_new - BITS_W'(cw_r);
    code_sh   = acc_new >> shamt;
    code_val  = CODE_W'(code_sh & ((ACC_W'(1) << cw_r) - 1'b1));

    full_code = NFC_W'(1) << smax_r;
    do_add    = add_r && (nfree_r < full_code);
    nf_after  = do_add ? nfree_r + 1'b1 : nfree_r;
    grow      = (nf_after > limit_r);
    cw_inc    = cw_r + 1'b1;
    c_sel     = (NFC_W'(code_r) >= nfree_r) ? prev_r : code_r;
  end

  always_comb begin
    state_nxt = state_r;  phase_nxt = phase_r;  tag_high_nxt = tag_high_r;
    smax_nxt = smax_r;    cw_nxt = cw_r;        limit_nxt = limit_r;
    nfree_nxt = nfree_r;  prev_nxt = prev_r;    code_nxt = code_r;
    c_nxt = c_r;          lfc_nxt = lfc_r;      acc_nxt = acc_r;
    bits_nxt = bits_r;    grp_nxt = grp_r;      last_nxt = last_r;
    add_nxt = add_r;      len_nxt = len_r;      idx_nxt = idx_r;
    pend_nxt = pend_r;
    load_en = 1'b0;  load_byte = '0;  load_eos = 1'b1;  load_status = ST_DATA;
    dict_we = 1'b0;  dict_raddr = c_r;
    stk_we = 1'b0;   stk_waddr = len_r[STK_AW-1:0];  stk_wdata = '0;  stk_raddr = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_ch.last_byte;
          unique case (phase_r)
            PH_TAG_HI: begin
              tag_high_nxt = in_ch.in_byte;
              if (in_ch.last_byte) begin
                pend_nxt = ST_BAD_TAG;  state_nxt = S_EMIT1;
              end else begin
                phase_nxt = PH_TAG_LO;
              end
            end
            PH_TAG_LO: begin
              if ({tag_high_r, in_ch.in_byte} != tag_r) begin
                pend_nxt  = ST_BAD_TAG;  state_nxt = S_EMIT1;
                phase_nxt = in_ch.last_byte ? PH_TAG_HI : PH_SKIP;
              end else if (in_ch.last_byte) begin
                pend_nxt = ST_END;  state_nxt = S_EMIT1;  phase_nxt = PH_TAG_HI;
              end else begin
                smax_nxt  = m_clamp;
                cw_nxt    = s_clamp;
                limit_nxt = (s_clamp == m_clamp) ? (NFC_W'(1) << s_clamp)
                                                 : (NFC_W'(1) << s_clamp) - 1'b1;
                nfree_nxt = NFC_W'(FIRST_CODE);
                prev_nxt  = '0;  lfc_nxt = '0;
                acc_nxt   = '0;  bits_nxt = '0;  grp_nxt = '0;
                phase_nxt = PH_FIRST;
              end
            end
            PH_FIRST, PH_DECODE: begin
              grp_nxt  = grp_dec;
              code_nxt = code_val;
              add_nxt  = (phase_r == PH_DECODE);
              if (grp_dec == '0) begin
                acc_nxt = '0;  bits_nxt = '0;
              end else begin
                acc_nxt  = acc_new;
                bits_nxt = have_code ? shamt : bits_new;
              end
              if (have_code) begin
                state_nxt = (phase_r == PH_FIRST) ? S_LIT : S_DSTART;
              end else if (in_ch.last_byte) begin
                pend_nxt = ST_END;  state_nxt = S_EMIT1;  phase_nxt = PH_TAG_HI;
              end
            end
            PH_DRAIN: begin
              if (grp_r != '0) grp_nxt = grp_r - 1'b1;
              if (grp_r <= CW_W'(1)) phase_nxt = PH_DECODE;
              if (in_ch.last_byte) begin
                pend_nxt = ST_END;  state_nxt = S_EMIT1;  phase_nxt = PH_TAG_HI;
              end
            end
            default: begin
              if (in_ch.last_byte) phase_nxt = PH_TAG_HI;
            end
          endcase
        end
      end
      S_LIT: begin
        if (slot_free) begin
          load_en = 1'b1;  load_byte = code_r[7:0];  load_eos = !last_r;
          lfc_nxt = code_r[7:0];
          prev_nxt = CODE_W'(code_r[7:0]);
          phase_nxt = PH_DECODE;
          state_nxt = S_FINISH;
        end
      end
      S_DSTART: begin
        if (NFC_W'(code_r) >= nfree_r) begin
          stk_we = 1'b1;  stk_waddr = '0;  stk_wdata = lfc_r;  len_nxt = LEN_W'(1);
        end else begin
          len_nxt = '0;
        end
        c_nxt      = c_sel;
        dict_raddr = c_sel;
        state_nxt  = (c_sel >= CODE_W'(FIRST_CODE)) ? S_WALK : S_TAIL;
      end
      S_WALK: begin
        if (len_r >= LEN_W'(MAX_STRING - 1)) begin
          pend_nxt = ST_OVF;  state_nxt = S_EMIT1;
          phase_nxt = last_r ? PH_TAG_HI : PH_SKIP;
        end else begin
          stk_we = 1'b1;  stk_wdata = sfx_q;
          len_nxt = len_r + 1'b1;
          c_nxt = pfx_q;  dict_raddr = pfx_q;
          if (pfx_q < CODE_W'(FIRST_CODE)) state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        if (len_r >= LEN_W'(MAX_STRING - 1)) begin
          pend_nxt = ST_OVF;  state_nxt = S_EMIT1;
          phase_nxt = last_r ? PH_TAG_HI : PH_SKIP;
        end else begin
          stk_we = 1'b1;  stk_wdata = c_r[7:0];
          lfc_nxt = c_r[7:0];
          idx_nxt = len_r[STK_AW-1:0];
          state_nxt = S_POP_RD;
        end
      end
      S_POP_RD: begin
        state_nxt = S_POP;
      end
      S_POP: begin
        if (slot_free) begin
          load_en = 1'b1;  load_byte = stk_q;  load_eos = (idx_r == '0) && !last_r;
          if (idx_r == '0) begin
            state_nxt = S_FINISH;
          end else begin
            idx_nxt = idx_r - 1'b1;  stk_raddr = idx_r - 1'b1;
          end
        end
      end
      S_FINISH: begin
        dict_we   = do_add;
        nfree_nxt = nf_after;
        if (add_r) prev_nxt = code_r;
        if (grow) begin
          cw_nxt    = cw_inc;
          limit_nxt = (cw_inc >= smax_r) ? full_code : (NFC_W'(1) << cw_inc) - 1'b1;
          bits_nxt  = '0;  acc_nxt = '0;
          if (grp_r != '0) phase_nxt = PH_DRAIN;
        end
        if (last_r) begin
          pend_nxt = ST_END;  phase_nxt = PH_TAG_HI;  state_nxt = S_EMIT1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT1: begin
        if (slot_free) begin
          load_en = 1'b1;  load_status = pend_r;  state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  phase_r <= PH_TAG_HI;
      smax_r <= CW_W'(MAX_BITS);  cw_r <= CW_W'(MIN_BITS);
      limit_r <= NFC_W'((1 << MIN_BITS) - 1);  nfree_r <= NFC_W'(FIRST_CODE);
      prev_r <= '0;  lfc_r <= '0;  acc_r <= '0;  bits_r <= '0;  grp_r <= '0;
      tag_high_r <= '0;  out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  phase_r <= phase_nxt;
      smax_r <= smax_nxt;  cw_r <= cw_nxt;  limit_r <= limit_nxt;  nfree_r <= nfree_nxt;
      prev_r <= prev_nxt;  lfc_r <= lfc_nxt;  acc_r <= acc_nxt;  bits_r <= bits_nxt;
      grp_r <= grp_nxt;  tag_high_r <= tag_high_nxt;
      if (load_en) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;  c_r <= c_nxt;  last_r <= last_nxt;  add_r <= add_nxt;
    len_r <= len_nxt;  idx_r <= idx_nxt;  pend_r <= pend_nxt;
    if (load_en) begin
      out_byte_r <= load_byte;  out_eos_r <= load_eos;  out_status_r <= load_status;
    end
  end

  a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cw_r <= smax_r) else $error("code width beyond stream maximum");
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfree_r <= (NFC_W'(1) << smax_r)) else $error("next free code beyond dictionary");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (NFC_W'(idx_r) < NFC_W'(MAX_STRING - 1)))
    else $error("string stack index out of range");

endmodule
